>>> rtl/core/dtmf_pkg.sv
// ----------------------------------------------------------------------------
// dtmf_pkg
// Shared constants for the DTMF tone generator: keypad frequency tables,
// sine series divisors, register map and default parameter values.
// ----------------------------------------------------------------------------
package dtmf_pkg;

  // Default build values
  localparam int DEF_PHASE_BITS     = 32;
  localparam int DEF_SINE_ADDR_BITS = 10;
  localparam int DEF_SAMPLE_RATE_HZ = 16000;

  // Register map (word index on the config port)
  localparam logic REG_TONE_SAMPLES = 1'b0;
  localparam logic REG_AMPLITUDE    = 1'b1;

  localparam int CFG_ADDR_BITS = 3;

  // Register reset values
  localparam logic [15:0] TONE_SAMPLES_RST = 16'd4000;
  localparam logic [13:0] AMPLITUDE_RST    = 14'd16383;

  // Frequency width (largest tone is 1633 Hz)
  localparam int FREQ_BITS = 11;

  // Keypad index -> row / column tone in Hz
  localparam logic [FREQ_BITS-1:0] ROW_FREQ [16] = '{
    11'd941, 11'd697, 11'd697, 11'd697, 11'd770, 11'd770, 11'd770, 11'd852,
    11'd852, 11'd852, 11'd697, 11'd770, 11'd852, 11'd941, 11'd941, 11'd941
  };
  localparam logic [FREQ_BITS-1:0] COL_FREQ [16] = '{
    11'd1336, 11'd1209, 11'd1336, 11'd1477, 11'd1209, 11'd1336, 11'd1477, 11'd1209,
    11'd1336, 11'd1477, 11'd1633, 11'd1633, 11'd1633, 11'd1633, 11'd1209, 11'd1477
  };

  // Horner divisors of the sine series through z^11
  localparam logic [63:0] TAYLOR_DIV [5] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

  // pi/2 and 1.0 in Q30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

endpackage

>>> rtl/core/dtmf_tone_generator_unit.sv
// Path: an accepted input word is registered in the sine ROM stage, then in the result register.
// Throughput: one word per cycle; a new word is taken each cycle while the
//   sine ROM stage can move forward (set by the result register being free or drained).
// Reset: synchronous, active low; registers return to 4000 samples and
//   full amplitude, phases clear, the tone is silent and the pipe is empty.
// ----------------------------------------------------------------------------
// dtmf_tone_generator_unit
// Dual-tone sample generator: phase accumulators, two-port sine ROM,
// amplitude scaling and sum, with an APB-style register port.
// ----------------------------------------------------------------------------
module dtmf_tone_generator_unit
  import dtmf_pkg::*;
#(
  parameter int PHASE_BITS     = DEF_PHASE_BITS,
  parameter int SINE_ADDR_BITS = DEF_SINE_ADDR_BITS,
  parameter int SAMPLE_RATE_HZ = DEF_SAMPLE_RATE_HZ
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // input channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_start_req,
  input  logic [3:0]               in_key,
  // result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [15:0]       out_sample,
  output logic                     out_tone_active,
  // config port
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [31:0]              cfg_pwdata,
  output logic [31:0]              cfg_prdata,
  output logic                     cfg_pready
);

  localparam int ROM_DEPTH = 1 << SINE_ADDR_BITS;
  localparam int QTR_BITS  = SINE_ADDR_BITS - 2;
  localparam logic [63:0] QTR_DEPTH = 64'd1 << QTR_BITS;

  typedef logic signed [15:0]   sine_rom_t [ROM_DEPTH];
  typedef logic [PHASE_BITS-1:0] inc_tab_t [16];

  // sin(pi/2 * p / QTR_DEPTH) in Q15, 0 <= p <= QTR_DEPTH
  function automatic logic [15:0] quarter_sine(input logic [63:0] p);
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] acc;
    logic [63:0] t;
    logic [63:0] s;
    z   = (p * HALF_PI_Q30) / QTR_DEPTH;
    z2  = (z * z) >> 30;
    acc = ONE_Q30;
    for (int i = 0; i < 5; i++) begin
      t   = ((z2 * acc) >> 30) / TAYLOR_DIV[i];
      acc = (t >= ONE_Q30) ? 64'd0 : (ONE_Q30 - t);
    end
    s = (z * acc) >> 30;
    s = (s + (64'd1 << 14)) >> 15;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return s[15:0];
  endfunction

  // Full-wave table built from the first quadrant by mirror and negate
  function automatic sine_rom_t build_rom();
    sine_rom_t   rom;
    logic [63:0] p;
    logic [1:0]  quad;
    logic [15:0] v;
    for (int a = 0; a < ROM_DEPTH; a++) begin
      quad = 2'(a >> QTR_BITS);
      p    = 64'(a) & (QTR_DEPTH - 64'd1);
      if (quad[0]) begin
        p = QTR_DEPTH - p;
      end
      v      = quarter_sine(p);
      rom[a] = quad[1] ? -$signed(v) : $signed(v);
    end
    return rom;
  endfunction

  // round(f * 2^PHASE_BITS / rate), ties up, modulo 2^PHASE_BITS
  function automatic inc_tab_t build_inc(input logic use_col);
    inc_tab_t    tab;
    logic [63:0] num;
    logic [63:0] q;
    for (int k = 0; k < 16; k++) begin
      num    = (64'(use_col ? COL_FREQ[k] : ROW_FREQ[k]) << PHASE_BITS)
               + 64'(SAMPLE_RATE_HZ / 2);
      q      = num / 64'(SAMPLE_RATE_HZ);
      tab[k] = q[PHASE_BITS-1:0];
    end
    return tab;
  endfunction

  localparam sine_rom_t SINE_ROM = build_rom();
  localparam inc_tab_t  ROW_INC  = build_inc(1'b0);
  localparam inc_tab_t  COL_INC  = build_inc(1'b1);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic [15:0]           tone_samples_r;
  logic [13:0]           amplitude_r;
  logic [3:0]            held_key_r;
  logic [PHASE_BITS-1:0] row_phase_r;
  logic [PHASE_BITS-1:0] col_phase_r;
  logic [15:0]           sample_count_r;

  logic                  s1_valid_r;
  logic                  s1_active_r;
  logic signed [15:0]    row_sin_r;
  logic signed [15:0]    col_sin_r;

  logic                  out_valid_r;
  logic                  out_active_r;
  logic signed [15:0]    out_sample_r;

  // --------------------------------------------------------------------------
  // Config port
  // --------------------------------------------------------------------------
  logic cfg_wr;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    case (cfg_paddr[2])
      REG_TONE_SAMPLES: cfg_prdata = {16'd0, tone_samples_r};
      REG_AMPLITUDE:    cfg_prdata = {18'd0, amplitude_r};
      default:          cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_samples_r <= TONE_SAMPLES_RST;
      amplitude_r    <= AMPLITUDE_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_TONE_SAMPLES: tone_samples_r <= cfg_pwdata[15:0];
        REG_AMPLITUDE:    amplitude_r    <= cfg_pwdata[13:0];
        default:          tone_samples_r <= tone_samples_r;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipe handshake: result reg loads when free, ROM stage when it can drain
  // --------------------------------------------------------------------------
  logic out_load;
  logic s1_en;
  logic in_fire;

  assign out_load = !out_valid_r || out_ready;
  assign s1_en    = !s1_valid_r || out_load;
  assign in_ready = s1_en;
  assign in_fire  = in_valid && s1_en;

  // --------------------------------------------------------------------------
  // Tone state: start override, duration check, phase step
  // --------------------------------------------------------------------------
  logic [3:0]            key_eff;
  logic [PHASE_BITS-1:0] row_eff;
  logic [PHASE_BITS-1:0] col_eff;
  logic [15:0]           count_eff;
  logic                  active;
  logic [3:0]            held_key_nxt;
  logic [PHASE_BITS-1:0] row_phase_nxt;
  logic [PHASE_BITS-1:0] col_phase_nxt;
  logic [15:0]           sample_count_nxt;

  always_comb begin
    key_eff   = in_start_req ? in_key : held_key_r;
    row_eff   = in_start_req ? '0 : row_phase_r;
    col_eff   = in_start_req ? '0 : col_phase_r;
    count_eff = in_start_req ? 16'd0 : sample_count_r;
    active    = count_eff < tone_samples_r;

    held_key_nxt     = key_eff;
    row_phase_nxt    = row_eff;
    col_phase_nxt    = col_eff;
    sample_count_nxt = count_eff;
    if (active) begin
      row_phase_nxt    = row_eff + ROW_INC[key_eff];
      col_phase_nxt    = col_eff + COL_INC[key_eff];
      sample_count_nxt = count_eff + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_key_r     <= 4'd0;
      row_phase_r    <= '0;
      col_phase_r    <= '0;
      sample_count_r <= 16'hFFFF;
    end else if (in_fire) begin
      held_key_r     <= held_key_nxt;
      row_phase_r    <= row_phase_nxt;
      col_phase_r    <= col_phase_nxt;
      sample_count_r <= sample_count_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Sine ROM stage: two registered reads at the phase tops
  // --------------------------------------------------------------------------
  logic [SINE_ADDR_BITS-1:0] row_addr;
  logic [SINE_ADDR_BITS-1:0] col_addr;

  assign row_addr = row_eff[PHASE_BITS-1 -: SINE_ADDR_BITS];
  assign col_addr = col_eff[PHASE_BITS-1 -: SINE_ADDR_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_active_r <= active;
      row_sin_r   <= SINE_ROM[row_addr];
      col_sin_r   <= SINE_ROM[col_addr];
    end
  end

  // --------------------------------------------------------------------------
  // Scale, truncate toward zero, sum and clamp; zero while the tone is silent
  // --------------------------------------------------------------------------
  logic signed [30:0] row_prod;
  logic signed [30:0] col_prod;
  logic signed [30:0] row_bias;
  logic signed [30:0] col_bias;
  logic signed [16:0] sum;
  logic signed [15:0] out_sample_nxt;

  always_comb begin
    row_prod = $signed({1'b0, amplitude_r}) * row_sin_r;
    col_prod = $signed({1'b0, amplitude_r}) * col_sin_r;
    // negative products get 2^15-1 added so the shift rounds toward zero
    row_bias = row_prod + (row_prod[30] ? 31'sd32767 : 31'sd0);
    col_bias = col_prod + (col_prod[30] ? 31'sd32767 : 31'sd0);
    sum      = {row_bias[30], row_bias[30:15]} + {col_bias[30], col_bias[30:15]};
    if (!s1_active_r) begin
      out_sample_nxt = 16'sd0;
    end else if (sum > 17'sd32767) begin
      out_sample_nxt = 16'sh7FFF;
    end else if (sum < -17'sd32768) begin
      out_sample_nxt = 16'sh8000;
    end else begin
      out_sample_nxt = sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid_r) begin
      out_sample_r <= out_sample_nxt;
      out_active_r <= s1_active_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sample      = out_sample_r;
  assign out_tone_active = out_active_r;

endmodule

>>> rtl/core/dtmf_chk.sv
// ----------------------------------------------------------------------------
// dtmf_chk
// Port-level checks for the DTMF tone generator, bound to the top level.
// ----------------------------------------------------------------------------
module dtmf_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [15:0] out_sample,
  input logic              out_tone_active,
  input logic              cfg_pready
);

  // silence always carries a zero sample
  a_silent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_tone_active) |-> (out_sample == 16'sd0))
    else $error("silent word with nonzero sample");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid after reset");

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_sample)
                                   && $stable(out_tone_active)))
    else $error("stalled result word changed");

  // input side keeps taking words while the result side drains
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled with result side free");

  // config port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("config port inserted wait state");

endmodule

bind dtmf_tone_generator_unit dtmf_chk u_dtmf_chk (.*);
